FILE: rtl/tci_pkg.sv
package tci_pkg;

    localparam int CHANNELS          = 4;
    localparam int SAMPLE_BITS       = 16;
    localparam int TIME_BITS         = 32;
    localparam int AXIS_BITS         = 2;
    localparam int CFG_DATA_BITS     = 16;
    localparam int FRACTION_BITS_DEF = 16;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] sample_time;
        sample_t              chan0;
        sample_t              chan1;
        sample_t              chan2;
        sample_t              chan3;
    } in_item_t;

    typedef struct packed {
        logic                 falling;
        logic [TIME_BITS-1:0] cross_time;
        sample_t              out0;
        sample_t              out1;
        sample_t              out2;
        sample_t              out3;
    } out_item_t;

    typedef enum logic [1:0] {
        REG_CROSS_LEVEL    = 2'd0,
        REG_AXIS_SELECT    = 2'd1,
        REG_REPORT_RISING  = 2'd2,
        REG_REPORT_FALLING = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_MULTIPLY,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef struct packed {
        logic load;
        logic step;
        logic fbit;
        logic last;
    } lane_ctrl_t;

endpackage

FILE: rtl/tci_divider.sv
module tci_divider #(
    parameter int MAG_BITS  = tci_pkg::SAMPLE_BITS,
    parameter int FRAC_BITS = tci_pkg::FRACTION_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [MAG_BITS-1:0]   num,
    input  logic [MAG_BITS-1:0]   den,
    output logic [FRAC_BITS:0]    quot,
    output tci_pkg::div_status_t  status
);
    import tci_pkg::*;

    localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [MAG_BITS-1:0] rem_reg;
    logic [MAG_BITS-1:0] den_reg;
    logic [FRAC_BITS:0]  quot_reg;

    logic [MAG_BITS:0]   shifted;
    logic [MAG_BITS:0]   trial;
    logic                ge;
    logic [MAG_BITS-1:0] rem_next;
    logic                last_step;

    // first step tests the integer bit, the rest shift the remainder
    always_comb begin
        shifted   = (count_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        trial     = shifted - {1'b0, den_reg};
        ge        = shifted >= {1'b0, den_reg};
        rem_next  = ge ? trial[MAG_BITS-1:0] : shifted[MAG_BITS-1:0];
        last_step = count_reg == CNT_BITS'(FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
                rem_reg   <= num;
                den_reg   <= den;
            end else if (busy_reg) begin
                rem_reg   <= rem_next;
                quot_reg  <= {quot_reg[FRAC_BITS-1:0], ge};
                count_reg <= count_reg + 1'b1;
                if (last_step) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quot        = quot_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

FILE: rtl/tci_lane.sv
module tci_lane #(
    parameter int WIDTH = tci_pkg::SAMPLE_BITS
) (
    input  logic                 aclk,
    input  tci_pkg::lane_ctrl_t  ctrl,
    input  logic [WIDTH-1:0]     base_in,
    input  logic signed [WIDTH:0] diff_in,
    output logic [WIDTH-1:0]     result
);
    import tci_pkg::*;

    logic [WIDTH-1:0]        base_reg;
    logic signed [WIDTH:0]   diff_reg;
    logic signed [WIDTH+1:0] acc_reg;

    logic signed [WIDTH+1:0] addend;
    logic signed [WIDTH+1:0] sum;
    logic signed [WIDTH+1:0] acc_next;

    // fraction bits arrive lsb first; the top bit has weight one and takes no shift
    always_comb begin
        addend   = ctrl.fbit ? {diff_reg[WIDTH], diff_reg} : '0;
        sum      = acc_reg + addend;
        acc_next = ctrl.last ? sum : (sum >>> 1);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            base_reg <= base_in;
            diff_reg <= diff_in;
            acc_reg  <= '0;
        end else if (ctrl.step) begin
            acc_reg <= acc_next;
        end
    end

    assign result = base_reg + acc_reg[WIDTH-1:0];

endmodule

FILE: rtl/threshold_crossing_interpolator.sv
// Level-crossing detector with linear interpolation. Each sample (timestamp and four signed
// channels) is compared with the one before it; when the channel picked by axis_select meets
// or crosses cross_level, one result carries the direction, the interpolated time and all
// channels interpolated at the same fraction. A sample that gives no result leaves the block
// ready, so the next can follow at once. For a sample that gives a result, the bit-serial
// restoring divider forms the fraction, then all lanes run bit-serial shift-add in parallel,
// and the output register is loaded; no new sample is taken until then. The result sits in
// an output register, so the next sample is taken while it waits; only a second result waits
// for the first to go. Configuration writes are always taken and apply from the next accepted
// sample.
module threshold_crossing_interpolator #(
    parameter int FRACTION_BITS = tci_pkg::FRACTION_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tci_pkg::in_item_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tci_pkg::out_item_t                  m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  tci_pkg::reg_index_t                 cfg_index,
    input  logic [tci_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import tci_pkg::*;

    localparam int CNT_BITS = $clog2(FRACTION_BITS + 1);

    typedef logic signed [SAMPLE_BITS:0] wide_t;

    state_t state_reg, state_next;

    sample_t              cross_level_reg;
    logic [AXIS_BITS-1:0] axis_select_reg;
    logic                 report_rising_reg;
    logic                 report_falling_reg;

    logic [TIME_BITS-1:0] prev_time_reg;
    sample_t              prev_chan_reg [CHANNELS];
    logic                 have_prev_reg;

    logic                 falling_reg;
    logic [FRACTION_BITS:0] frac_reg;
    logic [CNT_BITS-1:0]  mul_count_reg;

    logic                 m_valid_reg;
    out_item_t            m_data_reg;

    sample_t              cur_chan [CHANNELS];
    sample_t              x0, x1;
    wide_t                num_s, den_s;
    wide_t                num_abs, den_abs;
    logic                 axis_ok, rise, fall, emit_r, emit_f, emit;
    logic                 accept;

    logic                 div_start;
    logic [FRACTION_BITS:0] div_quot;
    div_status_t          div_status;
    lane_ctrl_t           lane_ctrl;
    logic                 out_load;
    logic                 mul_last;

    logic signed [TIME_BITS:0]   time_diff;
    logic [TIME_BITS-1:0]        time_result;
    logic signed [SAMPLE_BITS:0] chan_diff   [CHANNELS];
    sample_t                     chan_result [CHANNELS];

    // crossing test on the incoming sample against the stored one
    always_comb begin
        cur_chan[0] = s_data.chan0;
        cur_chan[1] = s_data.chan1;
        cur_chan[2] = s_data.chan2;
        cur_chan[3] = s_data.chan3;

        x0      = prev_chan_reg[axis_select_reg];
        x1      = cur_chan[axis_select_reg];
        axis_ok = {1'b0, axis_select_reg} < (AXIS_BITS + 1)'(CHANNELS);
        rise    = (x0 <= cross_level_reg) && (x1 >= cross_level_reg);
        fall    = (x0 >= cross_level_reg) && (x1 <= cross_level_reg);
        emit_r  = rise && report_rising_reg;
        emit_f  = fall && report_falling_reg;
        emit    = have_prev_reg && axis_ok && (x0 != x1) && (emit_r || emit_f);

        num_s   = wide_t'(cross_level_reg) - wide_t'(x0);
        den_s   = wide_t'(x1) - wide_t'(x0);
        num_abs = num_s[SAMPLE_BITS] ? -num_s : num_s;
        den_abs = den_s[SAMPLE_BITS] ? -den_s : den_s;

        time_diff = $signed({1'b0, s_data.sample_time}) - $signed({1'b0, prev_time_reg});
        for (int i = 0; i < CHANNELS; i++) begin
            chan_diff[i] = wide_t'(cur_chan[i]) - wide_t'(prev_chan_reg[i]);
        end
    end

    assign accept   = s_valid && s_ready;
    assign mul_last = mul_count_reg == CNT_BITS'(FRACTION_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        div_start      = 1'b0;
        out_load       = 1'b0;
        lane_ctrl.load = 1'b0;
        lane_ctrl.step = 1'b0;
        lane_ctrl.fbit = frac_reg[0];
        lane_ctrl.last = mul_last;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && emit) begin
                    div_start      = 1'b1;
                    lane_ctrl.load = 1'b1;
                    state_next     = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_status.done) begin
                    state_next = ST_MULTIPLY;
                end
            end
            ST_MULTIPLY: begin
                lane_ctrl.step = 1'b1;
                if (mul_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cross_level_reg    <= '0;
            axis_select_reg    <= '0;
            report_rising_reg  <= 1'b1;
            report_falling_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_CROSS_LEVEL:    cross_level_reg    <= cfg_data[SAMPLE_BITS-1:0];
                REG_AXIS_SELECT:    axis_select_reg    <= cfg_data[AXIS_BITS-1:0];
                REG_REPORT_RISING:  report_rising_reg  <= cfg_data[0];
                REG_REPORT_FALLING: report_falling_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // every accepted sample becomes the previous one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
        end else if (accept) begin
            have_prev_reg <= 1'b1;
            prev_time_reg <= s_data.sample_time;
            for (int i = 0; i < CHANNELS; i++) begin
                prev_chan_reg[i] <= cur_chan[i];
            end
            if (emit) begin
                falling_reg <= emit_f;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIVIDE && div_status.done) begin
            frac_reg      <= div_quot;
            mul_count_reg <= '0;
        end else if (state_reg == ST_MULTIPLY) begin
            frac_reg      <= frac_reg >> 1;
            mul_count_reg <= mul_count_reg + 1'b1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.falling    <= falling_reg;
            m_data_reg.cross_time <= time_result;
            m_data_reg.out0       <= chan_result[0];
            m_data_reg.out1       <= chan_result[1];
            m_data_reg.out2       <= chan_result[2];
            m_data_reg.out3       <= chan_result[3];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    tci_divider #(
        .MAG_BITS  (SAMPLE_BITS),
        .FRAC_BITS (FRACTION_BITS)
    ) u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_abs[SAMPLE_BITS-1:0]),
        .den     (den_abs[SAMPLE_BITS-1:0]),
        .quot    (div_quot),
        .status  (div_status)
    );

    tci_lane #(
        .WIDTH (TIME_BITS)
    ) u_time_lane (
        .aclk    (aclk),
        .ctrl    (lane_ctrl),
        .base_in (prev_time_reg),
        .diff_in (time_diff),
        .result  (time_result)
    );

    for (genvar g = 0; g < CHANNELS; g++) begin : g_chan_lane
        tci_lane #(
            .WIDTH (SAMPLE_BITS)
        ) u_chan_lane (
            .aclk    (aclk),
            .ctrl    (lane_ctrl),
            .base_in (prev_chan_reg[g]),
            .diff_in (chan_diff[g]),
            .result  (chan_result[g])
        );
    end

    a_emit_starts_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && emit) |=> (state_reg == ST_DIVIDE) && div_status.busy)
        else $error("crossing sample did not start the divider");

    a_mul_after_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MULTIPLY) |-> !div_status.busy)
        else $error("multiply running while divider still busy");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result raised outside the finish step");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !out_load)
        else $error("pending result overwritten");

endmodule
